// ===== src/lsc_pkg.sv =====
// Shared types and constants for the LCD scan-line status controller.
// No dependencies; imported by every module of the block.
`default_nettype none

package lsc_pkg;

    // Line timing
    localparam int TOTAL_LINES   = 154;
    localparam int VISIBLE_LINES = 144;
    localparam int LINE_W        = 8;

    // Request kinds; the fourth code is unused and has no effect
    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_READ  = 2'd1,
        MODE_TICK  = 2'd2
    } mode_t;

    // I/O register offsets
    localparam logic [7:0] ADDR_SDATA = 8'h01;
    localparam logic [7:0] ADDR_SCTRL = 8'h02;
    localparam logic [7:0] ADDR_LCTRL = 8'h40;
    localparam logic [7:0] ADDR_LSTAT = 8'h41;
    localparam logic [7:0] ADDR_LINE  = 8'h44;
    localparam logic [7:0] ADDR_CMP   = 8'h45;

    // Reset values
    localparam logic [7:0] LCTRL_RESET = 8'h81;
    localparam logic [7:0] SCTRL_RESET = 8'h7E;

    // Status mode field values
    localparam logic [1:0] STAT_HBLANK = 2'd0;
    localparam logic [1:0] STAT_VBLANK = 2'd1;
    localparam logic [1:0] STAT_OAM    = 2'd2;
    localparam logic [1:0] STAT_XFER   = 2'd3;

    // Serial transfer length in bits
    localparam logic [3:0] SERIAL_BITS = 4'd8;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] address;
        logic [7:0] write_data;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       lcd_interrupt;
        logic       vblank_interrupt;
        logic       serial_interrupt;
        logic       draw_request;
        logic [7:0] draw_line_number;
    } result_t;

endpackage

`default_nettype wire

// ===== src/lcd_scanline_status_controller_unit.sv =====
// Top level of the LCD scan-line status controller.
// Uses lsc_pkg, lsc_in_stage, lsc_core and lsc_out_stage.
//
// Usage:
//   s_ channel: one request per accepted beat (s_valid && s_ready):
//   s_mode 0 register write, 1 register read, 2 phase tick; s_address is
//   the I/O register offset and s_write_data the byte for a write.
//   m_ channel: exactly one result per request, in order: read data,
//   LCD / vblank / serial interrupt pulses and the draw request for the
//   line just finished.
//   Path: an accepted request passes the input register, then the result
//   register, which presents its result on the m_ channel.
//   Throughput: one request per cycle when not stalled; the register update is a
//   single pass of logic between the input register and the result register.
//   Stall: while m_ready is low the result register holds; one more
//   request is still taken into the input register if it is empty, after
//   which s_ready drops until the result is taken.
//   Reset (aresetn low, synchronous): both stages empty, registers return
//   to their power-on values (LCD control 0x81, serial control 0x7E,
//   everything else zero).
`default_nettype none

module lcd_scanline_status_controller_unit
    import lsc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_mode,
    input  wire logic [7:0] s_address,
    input  wire logic [7:0] s_write_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_read_data,
    output logic            m_lcd_interrupt,
    output logic            m_vblank_interrupt,
    output logic            m_serial_interrupt,
    output logic            m_draw_request,
    output logic [7:0]      m_draw_line_number
);

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    res_ready;
    logic    step;
    result_t result;
    result_t out_res;

    assign in_item = '{mode: s_mode, address: s_address, write_data: s_write_data};

    // Request moves into the result register
    assign step = item_valid && res_ready;

    lsc_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (step)
    );

    lsc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item    (item),
        .step    (step),
        .result  (result)
    );

    lsc_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (item_valid),
        .res_ready (res_ready),
        .res       (result),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_res   (out_res)
    );

    assign m_read_data        = out_res.read_data;
    assign m_lcd_interrupt    = out_res.lcd_interrupt;
    assign m_vblank_interrupt = out_res.vblank_interrupt;
    assign m_serial_interrupt = out_res.serial_interrupt;
    assign m_draw_request     = out_res.draw_request;
    assign m_draw_line_number = out_res.draw_line_number;

endmodule

`default_nettype wire

// ===== src/lsc_in_stage.sv =====
// Input register of the controller: captures one request per cycle while free.
// Depends on lsc_pkg for the request type.
`default_nettype none

module lsc_in_stage
    import lsc_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire item_t in_item,
    output logic       item_valid,
    output item_t      item,
    input  wire logic  item_take
);

    logic  valid_reg;
    item_t item_reg;

    // Free when empty or when the held request moves on this cycle
    assign in_ready   = !valid_reg || item_take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // Valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    // Payload, no reset needed
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= in_item;
        end
    end

endmodule

`default_nettype wire

// ===== src/lsc_core.sv =====
// Register file and per-request update logic: register access, phase
// sequencing, line counter, status mode, interrupts and serial shift.
// Depends on lsc_pkg.
`default_nettype none

module lsc_core
    import lsc_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire item_t item,
    input  wire logic  step,
    output result_t    result
);

    localparam logic [LINE_W:0]   TOTAL_C   = (LINE_W + 1)'(TOTAL_LINES);
    localparam logic [LINE_W-1:0] VISIBLE_C = LINE_W'(VISIBLE_LINES);

    logic [1:0]        phase_reg,  phase_next;
    logic [7:0]        lctrl_reg,  lctrl_next;
    logic [7:0]        lstat_reg,  lstat_next;
    logic [LINE_W-1:0] line_reg,   line_next;
    logic [7:0]        cmp_reg,    cmp_next;
    logic [7:0]        sdata_reg,  sdata_next;
    logic [7:0]        sctrl_reg,  sctrl_next;
    logic [3:0]        sbits_reg,  sbits_next;

    logic [LINE_W:0]   line_sum;
    logic [LINE_W:0]   line_wrap;
    logic [3:0]        sbits_dec;

    // Line advance modulo the frame length; one compare and subtract
    assign line_sum  = {1'b0, line_reg} + (LINE_W + 1)'(1);
    assign line_wrap = (line_sum >= TOTAL_C) ? (line_sum - TOTAL_C) : line_sum;
    assign sbits_dec = sbits_reg - 4'd1;

    // Next state and result for the request in the input register
    always_comb begin
        phase_next = phase_reg;
        lctrl_next = lctrl_reg;
        lstat_next = lstat_reg;
        line_next  = line_reg;
        cmp_next   = cmp_reg;
        sdata_next = sdata_reg;
        sctrl_next = sctrl_reg;
        sbits_next = sbits_reg;
        result     = '0;

        unique case (item.mode)
            MODE_WRITE: begin
                unique case (item.address)
                    ADDR_SDATA: sdata_next = item.write_data;
                    ADDR_SCTRL: begin
                        // start bit and internal clock both set: begin a transfer
                        if (item.write_data[7] && item.write_data[0]) begin
                            sdata_next = 8'hFF;
                            sbits_next = SERIAL_BITS;
                        end else begin
                            sbits_next = 4'd0;
                        end
                        sctrl_next = item.write_data;
                    end
                    ADDR_LCTRL: lctrl_next = item.write_data;
                    ADDR_LSTAT: lstat_next = {item.write_data[7:3], lstat_reg[2:0]};
                    ADDR_LINE:  line_next  = '0;
                    ADDR_CMP:   cmp_next   = item.write_data;
                    default: ;
                endcase
            end
            MODE_READ: begin
                unique case (item.address)
                    ADDR_SDATA: result.read_data = sdata_reg;
                    ADDR_SCTRL: result.read_data = sctrl_reg;
                    ADDR_LCTRL: result.read_data = lctrl_reg;
                    ADDR_LSTAT: result.read_data = lstat_reg;
                    ADDR_LINE:  result.read_data = 8'(line_reg);
                    ADDR_CMP:   result.read_data = cmp_reg;
                    default:    result.read_data = 8'h00;
                endcase
            end
            MODE_TICK: begin
                unique case (phase_reg)
                    2'd0:    phase_next = 2'd1;
                    2'd1:    phase_next = 2'd2;
                    2'd2:    phase_next = 2'd0;
                    default: phase_next = 2'd1;
                endcase

                if (phase_next == 2'd1) begin
                    // OAM search
                    lstat_next[1:0]      = STAT_OAM;
                    result.lcd_interrupt = lstat_reg[5];
                end else if (phase_next == 2'd2) begin
                    // pixel transfer
                    lstat_next[1:0] = STAT_XFER;
                end else begin
                    // end of line
                    if (line_reg < VISIBLE_C) begin
                        result.draw_request     = 1'b1;
                        result.draw_line_number = 8'(line_reg);
                    end
                    if (lctrl_reg[7]) begin
                        // coincidence flag
                        if (8'(line_reg) == cmp_reg) begin
                            lstat_next[2] = 1'b1;
                            if (lstat_reg[6]) begin
                                result.lcd_interrupt = 1'b1;
                            end
                        end else begin
                            lstat_next[2] = 1'b0;
                        end

                        line_next = line_wrap[LINE_W-1:0];
                        if (line_next < VISIBLE_C) begin
                            lstat_next[1:0] = STAT_HBLANK;
                            if (lstat_reg[3]) begin
                                result.lcd_interrupt = 1'b1;
                            end
                        end else if (line_next == VISIBLE_C) begin
                            result.vblank_interrupt = 1'b1;
                            lstat_next[1:0]         = STAT_VBLANK;
                            if (lstat_reg[4]) begin
                                result.lcd_interrupt = 1'b1;
                            end
                        end

                        // serial shift, one bit per line
                        if (sbits_reg != 4'd0) begin
                            sdata_next = {sdata_reg[6:0], 1'b1};
                            sbits_next = sbits_dec;
                            if (sbits_dec == 4'd0) begin
                                sctrl_next[7]           = 1'b0;
                                result.serial_interrupt = 1'b1;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    // State registers, updated when the request moves to the result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= 2'd0;
            lctrl_reg <= LCTRL_RESET;
            lstat_reg <= 8'h00;
            line_reg  <= '0;
            cmp_reg   <= 8'h00;
            sdata_reg <= 8'h00;
            sctrl_reg <= SCTRL_RESET;
            sbits_reg <= 4'd0;
        end else if (step) begin
            phase_reg <= phase_next;
            lctrl_reg <= lctrl_next;
            lstat_reg <= lstat_next;
            line_reg  <= line_next;
            cmp_reg   <= cmp_next;
            sdata_reg <= sdata_next;
            sctrl_reg <= sctrl_next;
            sbits_reg <= sbits_next;
        end
    end

    // Line counter never leaves the frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, line_reg} < TOTAL_C)
        else $error("line counter out of range");

    // Phase counter only cycles through three values
    assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != 2'd3)
        else $error("phase counter out of range");

    // Serial count never exceeds one byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        sbits_reg <= SERIAL_BITS)
        else $error("serial bit count out of range");

    // A vblank interrupt leaves the counter on the first blank line
    assert property (@(posedge aclk) disable iff (!aresetn)
        (step && result.vblank_interrupt) |=> (line_reg == VISIBLE_C))
        else $error("vblank raised off the first blank line");

    // A serial interrupt leaves the transfer finished
    assert property (@(posedge aclk) disable iff (!aresetn)
        (step && result.serial_interrupt) |=> (sbits_reg == 4'd0 && !sctrl_reg[7]))
        else $error("serial interrupt with transfer still running");

endmodule

`default_nettype wire

// ===== src/lsc_out_stage.sv =====
// Result register of the controller: holds one result until taken.
// Depends on lsc_pkg for the result type.
`default_nettype none

module lsc_out_stage
    import lsc_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    res_valid,
    output logic         res_ready,
    input  wire result_t res,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_res
);

    logic    valid_reg;
    result_t res_reg;

    // Loads when empty or when the current result leaves this cycle
    assign res_ready = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    // Valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (res_ready) begin
            valid_reg <= res_valid;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            res_reg <= res;
        end
    end

endmodule

`default_nettype wire
